// ----- rtl/core/swpf_pkg.sv -----
// ---------------------------------------------------------------------------
// swpf_pkg
// Types and constants shared by the servo write packet framer modules.
// ---------------------------------------------------------------------------
package swpf_pkg;

    localparam int unsigned MAX_BYTES = 11;

    localparam logic [1:0] ACT_POSITION = 2'd0;
    localparam logic [1:0] ACT_SPEED    = 2'd1;
    localparam logic [1:0] ACT_LIMITS   = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] WRITE_INS = 8'h03;
    localparam logic [7:0] POS_ADDR  = 8'h1E;
    localparam logic [7:0] SPD_ADDR  = 8'h20;
    localparam logic [7:0] LIM_ADDR  = 8'h06;
    localparam logic [7:0] LEN_LONG  = 8'h07;
    localparam logic [7:0] LEN_SHORT = 8'h05;

    localparam logic [3:0] COUNT_LONG  = 4'd11;
    localparam logic [3:0] COUNT_SHORT = 4'd9;

    // floor(a*1023/300) == (a*GOAL_MULT) >> GOAL_SHIFT for every 9-bit a
    localparam logic [21:0] GOAL_MULT  = 22'd3575645;
    localparam int unsigned GOAL_SHIFT = 20;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] servo_id;
        logic [8:0] angle_deg;
        logic [9:0] speed;
        logic       direction;
    } cmd_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } tx_t;

    typedef struct packed {
        logic [3:0]                 count;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } packet_t;

endpackage

// ----- rtl/core/swpf_front.sv -----
// ---------------------------------------------------------------------------
// swpf_front
// Accepts commands, scales the goal angle and assembles the packet bytes
// with checksum, then hands the packet to the queue.
// ---------------------------------------------------------------------------
module swpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  swpf_pkg::cmd_t     cmd,
    output logic               push,
    input  logic               push_ready,
    output swpf_pkg::packet_t  push_pkt
);

    logic              s_valid_reg;
    logic              s_valid_next;
    swpf_pkg::cmd_t    s_cmd_reg;
    logic [10:0]       s_goal_reg;
    logic [30:0]       goal_prod;
    logic              accept;
    logic [10:0]       word;
    logic [7:0]        len;
    logic [7:0]        addr;
    logic [3:0][7:0]   params;
    logic [7:0]        sum;

    assign cmd_ready = !s_valid_reg || push_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign push      = s_valid_reg;

    assign goal_prod = 31'(cmd.angle_deg) * 31'(swpf_pkg::GOAL_MULT);

    always_comb
    begin
        // drop commands with the unused action code
        if (accept)
            s_valid_next = (cmd.action != swpf_pkg::ACT_UNUSED);
        else if (push_ready)
            s_valid_next = 1'b0;
        else
            s_valid_next = s_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= s_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_cmd_reg  <= cmd;
            s_goal_reg <= goal_prod[swpf_pkg::GOAL_SHIFT +: 11];
        end
    end

    always_comb
    begin
        word = {s_cmd_reg.direction, s_cmd_reg.speed};
        unique case (s_cmd_reg.action)
            swpf_pkg::ACT_POSITION:
            begin
                len    = swpf_pkg::LEN_LONG;
                addr   = swpf_pkg::POS_ADDR;
                params = {{5'd0, word[10:8]}, word[7:0],
                          {5'd0, s_goal_reg[10:8]}, s_goal_reg[7:0]};
            end
            swpf_pkg::ACT_SPEED:
            begin
                len    = swpf_pkg::LEN_SHORT;
                addr   = swpf_pkg::SPD_ADDR;
                params = {8'h00, 8'h00, {5'd0, word[10:8]}, word[7:0]};
            end
            default:
            begin
                len    = swpf_pkg::LEN_LONG;
                addr   = swpf_pkg::LIM_ADDR;
                params = {8'h03, 8'hFF, 8'h00, 8'h00};
            end
        endcase

        sum = s_cmd_reg.servo_id + len + swpf_pkg::WRITE_INS + addr
            + params[0] + params[1] + params[2] + params[3];

        push_pkt.bytes[0] = swpf_pkg::HDR_BYTE;
        push_pkt.bytes[1] = swpf_pkg::HDR_BYTE;
        push_pkt.bytes[2] = s_cmd_reg.servo_id;
        push_pkt.bytes[3] = len;
        push_pkt.bytes[4] = swpf_pkg::WRITE_INS;
        push_pkt.bytes[5] = addr;
        push_pkt.bytes[6] = params[0];
        push_pkt.bytes[7] = params[1];
        if (s_cmd_reg.action == swpf_pkg::ACT_SPEED)
        begin
            push_pkt.count     = swpf_pkg::COUNT_SHORT;
            push_pkt.bytes[8]  = ~sum;
            push_pkt.bytes[9]  = 8'h00;
            push_pkt.bytes[10] = 8'h00;
        end
        else
        begin
            push_pkt.count     = swpf_pkg::COUNT_LONG;
            push_pkt.bytes[8]  = params[2];
            push_pkt.bytes[9]  = params[3];
            push_pkt.bytes[10] = ~sum;
        end
    end

    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.action == swpf_pkg::ACT_UNUSED |=> !s_valid_reg)
        else $error("unused action reached the packet stage");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg && !push_ready |=> s_valid_reg && $stable(s_cmd_reg))
        else $error("stalled packet stage lost its command");

    a_goal_range: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> s_goal_reg <= 11'd1742)
        else $error("scaled goal out of range");

endmodule

// ----- rtl/core/swpf_queue.sv -----
// ---------------------------------------------------------------------------
// swpf_queue
// Two-entry packet queue between the assembly stage and the serializer.
// ---------------------------------------------------------------------------
module swpf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               push_ready,
    input  swpf_pkg::packet_t  push_pkt,
    input  logic               pop,
    output logic               pop_valid,
    output swpf_pkg::packet_t  pop_pkt
);

    swpf_pkg::packet_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_pkt    = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_pkt;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 && !do_push |=> count_reg == 2'd0)
        else $error("empty queue changed without a push");

endmodule

// ----- rtl/core/swpf_back.sv -----
// ---------------------------------------------------------------------------
// swpf_back
// Serializes queued packets one byte per cycle, while the receiver accepts, into the output register.
// ---------------------------------------------------------------------------
module swpf_back (
    input  logic               clk,
    input  logic               rst_n,
    output logic               pop,
    input  logic               pop_valid,
    input  swpf_pkg::packet_t  pop_pkt,
    output logic               tx_valid,
    input  logic               tx_ready,
    output swpf_pkg::tx_t      tx
);

    swpf_pkg::packet_t pkt_reg;
    logic [3:0]        idx_reg;
    logic [3:0]        idx_next;
    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    swpf_pkg::tx_t     out_reg;
    logic              adv;
    logic              last_byte;

    assign adv       = busy_reg && (!out_valid_reg || tx_ready);
    assign last_byte = (idx_reg == pkt_reg.count - 4'd1);
    // load the next packet right as the current one sends its checksum
    assign pop       = pop_valid && (!busy_reg || (adv && last_byte));

    assign tx_valid = out_valid_reg;
    assign tx       = out_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        priority if (pop)
        begin
            idx_next  = 4'd0;
            busy_next = 1'b1;
        end
        else if (adv)
        begin
            idx_next  = idx_reg + 4'd1;
            busy_next = !last_byte;
        end
        if (adv)
            out_valid_next = 1'b1;
        else if (tx_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            pkt_reg <= pop_pkt;
        if (adv)
        begin
            out_reg.tx_byte <= pkt_reg.bytes[idx_reg];
            out_reg.last    <= last_byte;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg < pkt_reg.count)
        else $error("byte index past end of packet");

    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> busy_reg && idx_reg == 4'd0)
        else $error("packet load did not restart serializer");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        adv && idx_reg <= 4'd1 |=> out_reg.tx_byte == swpf_pkg::HDR_BYTE && !out_reg.last)
        else $error("packet does not open with two header bytes");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !tx_ready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled output byte changed");

endmodule

// ----- rtl/core/servo_write_packet_framer_top.sv -----
// The first packet byte passes the front stage register, a queue entry, the packet
// register and the output register. Output runs one byte per cycle while tx_ready is
// high; position and limit packets are 11 bytes, speed packets 9. Packets stream
// back to back through a two-entry queue; unused action codes produce nothing.
// Reset: rst_n clears the queue, serializer and output valid; no packet pending.
// ---------------------------------------------------------------------------
// servo_write_packet_framer_top
// Frames servo write commands into header, id, length, instruction, address,
// parameter and checksum bytes.
// ---------------------------------------------------------------------------
module servo_write_packet_framer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  swpf_pkg::cmd_t  cmd,
    output logic            tx_valid,
    input  logic            tx_ready,
    output swpf_pkg::tx_t   tx
);

    logic              push;
    logic              push_ready;
    swpf_pkg::packet_t push_pkt;
    logic              pop;
    logic              pop_valid;
    swpf_pkg::packet_t pop_pkt;

    swpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .push       (push),
        .push_ready (push_ready),
        .push_pkt   (push_pkt)
    );

    swpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_pkt    (pop_pkt)
    );

    swpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_pkt    (pop_pkt),
        .tx_valid   (tx_valid),
        .tx_ready   (tx_ready),
        .tx         (tx)
    );

endmodule

// ----- dv/servo_packet_checker.sv -----
// ---------------------------------------------------------------------------
// servo_packet_checker
// Watches the command and byte channels of the servo write packet framer,
// frames each accepted command into its expected packet bytes and compares
// every accepted output byte, in order, against them.
// ---------------------------------------------------------------------------
module servo_packet_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  swpf_pkg::cmd_t  cmd,
    input  logic            tx_valid,
    input  logic            tx_ready,
    input  swpf_pkg::tx_t   tx,
    output int              fail_count,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    swpf_pkg::tx_t     expected_bytes[$];
    int                mismatches = 0;
    int                bytes_due  = 0;
    int                byte_seen  = 0;
    swpf_pkg::packet_t pkt;
    swpf_pkg::tx_t     want;
    int                k;

    assign fail_count  = mismatches;
    assign outstanding = bytes_due;

    // Build the full write packet for one command; count 0 for the unused action.
    function automatic swpf_pkg::packet_t frame_write_packet(input swpf_pkg::cmd_t c);
        swpf_pkg::packet_t p;
        logic [10:0]       speed_word;
        logic [10:0]       goal;
        logic [7:0]        params [4];
        logic [7:0]        len;
        logic [7:0]        addr;
        logic [7:0]        sum;
        int unsigned       nparam;
        int unsigned       scaled;
        p = '0;
        speed_word = {c.direction, c.speed};
        scaled = (c.angle_deg * 32'd1023) / 32'd300;
        goal = scaled[10:0];
        if (c.action == swpf_pkg::ACT_POSITION)
        begin
            params = '{goal[7:0], {5'b0, goal[10:8]},
                       speed_word[7:0], {5'b0, speed_word[10:8]}};
            nparam = 4;
            len = swpf_pkg::LEN_LONG;
            addr = swpf_pkg::POS_ADDR;
        end
        else if (c.action == swpf_pkg::ACT_SPEED)
        begin
            params = '{speed_word[7:0], {5'b0, speed_word[10:8]}, 8'h00, 8'h00};
            nparam = 2;
            len = swpf_pkg::LEN_SHORT;
            addr = swpf_pkg::SPD_ADDR;
        end
        else if (c.action == swpf_pkg::ACT_LIMITS)
        begin
            params = '{8'h00, 8'h00, 8'hFF, 8'h03};
            nparam = 4;
            len = swpf_pkg::LEN_LONG;
            addr = swpf_pkg::LIM_ADDR;
        end
        else
        begin
            return p;
        end
        p.bytes[0] = swpf_pkg::HDR_BYTE;
        p.bytes[1] = swpf_pkg::HDR_BYTE;
        p.bytes[2] = c.servo_id;
        p.bytes[3] = len;
        p.bytes[4] = swpf_pkg::WRITE_INS;
        p.bytes[5] = addr;
        sum = c.servo_id + len + swpf_pkg::WRITE_INS + addr;
        for (int i = 0; i < nparam; i++)
        begin
            p.bytes[6 + i] = params[i];
            sum = sum + params[i];
        end
        p.bytes[6 + nparam] = ~sum;
        p.count = 4'(7 + nparam);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                pkt = frame_write_packet(cmd);
                for (k = 0; k < pkt.count; k++)
                begin
                    want.tx_byte = pkt.bytes[k];
                    want.last    = (k == pkt.count - 1);
                    expected_bytes.push_back(want);
                end
            end
            if (tx_valid && tx_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("byte %0d: unexpected byte %02h last %b",
                                              byte_seen, tx.tx_byte, tx.last));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (tx.tx_byte !== want.tx_byte)
                        report_mismatch($sformatf("byte %0d: tx_byte %02h, want %02h",
                                                  byte_seen, tx.tx_byte, want.tx_byte));
                    if (tx.last !== want.last)
                        report_mismatch($sformatf("byte %0d: last %b, want %b",
                                                  byte_seen, tx.last, want.last));
                end
                byte_seen++;
            end
            bytes_due = expected_bytes.size();
        end
    end

endmodule

// ----- dv/tb_servo_write_packet_framer_top.sv -----
// ---------------------------------------------------------------------------
// tb_servo_write_packet_framer_top
// Drives servo write commands into the framer, directed corners first and
// then random commands, with random sender gaps and receiver stalls plus one
// long receiver hold-off; the checker beside the block judges every byte.
// ---------------------------------------------------------------------------
module tb_servo_write_packet_framer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int CMD_W        = $bits(swpf_pkg::cmd_t);

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           cmd_ready;
    swpf_pkg::cmd_t cmd       = '0;
    logic           tx_valid;
    logic           tx_ready  = 1'b0;
    swpf_pkg::tx_t  tx;

    int fail_count;
    int outstanding;
    int cmd_gap_pct   = 31;
    int rx_stall_pct  = 77;
    int hold_requests = 0;
    int holds_done    = 0;

    always #1 clk = ~clk;

    servo_write_packet_framer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .tx_valid  (tx_valid),
        .tx_ready  (tx_ready),
        .tx        (tx)
    );

    servo_packet_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .tx_valid    (tx_valid),
        .tx_ready    (tx_ready),
        .tx          (tx),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic swpf_pkg::cmd_t make_cmd(input logic [1:0] action,
                                                 input logic [7:0] id,
                                                 input logic [8:0] angle,
                                                 input logic [9:0] spd,
                                                 input logic dir);
        swpf_pkg::cmd_t c;
        c.action    = action;
        c.servo_id  = id;
        c.angle_deg = angle;
        c.speed     = spd;
        c.direction = dir;
        return c;
    endfunction

    // Offer one command; return at the edge where the transaction happens.
    task automatic send_cmd(input swpf_pkg::cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < cmd_gap_pct)
        begin
            cmd_valid <= 1'b0;
            cmd       <= swpf_pkg::cmd_t'(CMD_W'($urandom));
            @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                tx_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else
            begin
                tx_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin
        swpf_pkg::cmd_t c;
        int             sent;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd0,   9'd0,   10'd0,    1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd253, 9'd300, 10'd1023, 1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd1,   9'd301, 10'd512,  1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd255, 9'd511, 10'd1023, 1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd254, 9'd150, 10'd1,    1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'hAA,  9'd256, 10'h155,  1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'h55,  9'd1,   10'h2AA,  1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_SPEED,    8'd0,   9'd0,   10'd0,    1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_SPEED,    8'd253, 9'd511, 10'd1023, 1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_SPEED,    8'd17,  9'd300, 10'd1023, 1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_SPEED,    8'd255, 9'd0,   10'd0,    1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_LIMITS,   8'd0,   9'd0,   10'd0,    1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_LIMITS,   8'd253, 9'd511, 10'd1023, 1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_UNUSED,   8'd5,   9'd100, 10'd100,  1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_UNUSED,   8'd255, 9'd511, 10'd1023, 1'b1));
        send_cmd(make_cmd(swpf_pkg::ACT_LIMITS,   8'd254, 9'd42,  10'd7,    1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_UNUSED,   8'd0,   9'd0,   10'd0,    1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_POSITION, 8'd128, 9'd299, 10'd1000, 1'b0));
        send_cmd(make_cmd(swpf_pkg::ACT_SPEED,    8'd200, 9'd0,   10'd300,  1'b1));

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                cmd_gap_pct  = 77;
                rx_stall_pct = 31;
            end
            else if (phase == 2)
            begin
                cmd_gap_pct  = 0;
                rx_stall_pct = 0;
                // Hold the receiver off so the framer fills and stalls its input.
                hold_requests++;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                c.action    = ($urandom_range(99) < 8) ? swpf_pkg::ACT_UNUSED
                                                       : 2'($urandom_range(2));
                c.servo_id  = ($urandom_range(9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(253));
                c.angle_deg = ($urandom_range(9) == 0) ? 9'($urandom)
                                                       : 9'($urandom_range(300));
                c.speed     = 10'($urandom);
                c.direction = 1'($urandom);
                send_cmd(c);
                if (c.action != swpf_pkg::ACT_UNUSED)
                    sent++;
            end
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("servo_write_packet_framer_top test passed");
        else
            $display("servo_write_packet_framer_top test failed");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("servo_write_packet_framer_top test failed");
        $finish;
    end

endmodule

// ----- servo_write_packet_framer_top.f -----
rtl/core/swpf_pkg.sv
rtl/core/swpf_front.sv
rtl/core/swpf_queue.sv
rtl/core/swpf_back.sv
rtl/core/servo_write_packet_framer_top.sv
dv/servo_packet_checker.sv
dv/tb_servo_write_packet_framer_top.sv
